/* rtl/bia_pkg.sv */
// ----------------------------------------------------------------------------
// bia_pkg: shared types and constants of the bitmap id allocator
// command and status codes, the classified command word and small helpers
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

  localparam int IDX_W       = 12;   // bit index width on the ports
  localparam int CFG_W       = 8;    // words_in_use register width
  localparam int WORD_W      = 32;   // map word width
  localparam int OFF_W       = 5;    // bit offset within a map word
  localparam int QUEUE_DEPTH = 2;    // command queue between front and back

  localparam logic [CFG_W-1:0]  WORDS_RESET = 8'd128;
  localparam logic [WORD_W-1:0] FULL_WORD   = 32'hffff_ffff;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_SET   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // command word after classification in the front
  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] bit_index;
    logic             in_range;
  } op_t;

  // status from the back to the front
  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // position of the lowest zero bit, zero for an all-ones word
  function automatic logic [OFF_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [OFF_W-1:0] pos;
    pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!w[b]) begin
        pos = OFF_W'(b);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

/* rtl/bia_ram.sv */
// ----------------------------------------------------------------------------
// bia_ram: generic single-write, single-read memory
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
`default_nettype none

module bia_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 128,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/bia_fifo.sv */
// ----------------------------------------------------------------------------
// bia_fifo: short command queue between front and back
// holds classified command words so each side can stall on its own
// ----------------------------------------------------------------------------
`default_nettype none

module bia_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bia_pkg::op_t  push_data,
  input  logic          pop,
  output bia_pkg::op_t  pop_data,
  output logic          empty,
  output logic          full
);

  import bia_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

  op_t           mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(QUEUE_DEPTH));

endmodule

`default_nettype wire

/* rtl/bia_front.sv */
// ----------------------------------------------------------------------------
// bia_front: input side of the allocator
// holds words_in_use, accepts command words and tags free/set range checks
// ----------------------------------------------------------------------------
`default_nettype none

module bia_front #(
  parameter  int MAP_BITS = 4096,
  localparam int WCNT_W   = $clog2(MAP_BITS / 32 + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic [bia_pkg::IDX_W-1:0]  in_bit_index,
  input  logic                       cfg_wr_en,
  input  logic [bia_pkg::CFG_W-1:0]  cfg_words_in_use,
  input  logic                       q_full,
  input  bia_pkg::back_stat_t        back_stat,
  output logic                       q_push,
  output bia_pkg::op_t               q_data,
  output logic [WCNT_W-1:0]          words_act
);

  import bia_pkg::*;

  localparam int MAX_WORDS = MAP_BITS / 32;
  localparam int CMP_W     = (WCNT_W > CFG_W) ? WCNT_W : CFG_W;
  localparam int LIM_W     = CMP_W + OFF_W;

  logic [CFG_W-1:0] words_cfg_r;
  logic [CMP_W-1:0] cfg_ext, max_ext, words_sel;
  logic [LIM_W-1:0] bit_limit, bit_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_cfg_r <= WORDS_RESET;
    end else if (cfg_wr_en) begin
      words_cfg_r <= cfg_words_in_use;
    end
  end

  // clamp to the words the map really has
  assign cfg_ext   = CMP_W'(words_cfg_r);
  assign max_ext   = CMP_W'(MAX_WORDS);
  assign words_sel = (cfg_ext < max_ext) ? cfg_ext : max_ext;
  assign words_act = WCNT_W'(words_sel);

  assign bit_limit = {words_sel, {OFF_W{1'b0}}};
  assign bit_ext   = LIM_W'(in_bit_index);

  assign in_ready  = !q_full && !back_stat.clearing;
  assign q_push    = in_valid && in_ready;

  always_comb begin
    q_data.cmd       = cmd_t'(in_cmd);
    q_data.bit_index = in_bit_index;
    q_data.in_range  = (bit_ext < bit_limit);
  end

endmodule

`default_nettype wire

/* rtl/bia_back.sv */
// ----------------------------------------------------------------------------
// bia_back: command engine of the allocator
// clears the map after reset, runs the hint scan and bit updates on the map
// memory and holds the result word until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module bia_back #(
  parameter  int MAP_BITS = 4096,
  localparam int AW       = (MAP_BITS / 32 > 1) ? $clog2(MAP_BITS / 32) : 1,
  localparam int WCNT_W   = $clog2(MAP_BITS / 32 + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  bia_pkg::op_t               q_data,
  input  logic [WCNT_W-1:0]          words_act,
  output bia_pkg::back_stat_t        back_stat,
  output logic                       ram_we,
  output logic [AW-1:0]              ram_waddr,
  output logic [bia_pkg::WORD_W-1:0] ram_wdata,
  output logic                       ram_re,
  output logic [AW-1:0]              ram_raddr,
  input  logic [bia_pkg::WORD_W-1:0] ram_rdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bia_pkg::IDX_W-1:0]  out_result_index,
  output logic [1:0]                 out_status,
  output logic                       out_was_set
);

  import bia_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

  localparam int MAX_WORDS = MAP_BITS / 32;
  localparam int LFB_W     = $clog2(2 * MAP_BITS);
  localparam int LB_W      = (LFB_W > IDX_W) ? LFB_W : IDX_W;
  localparam int HW        = WCNT_W + 1;
  localparam logic [AW-1:0] CLR_END_ADDR = AW'(MAX_WORDS - 1);

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [AW-1:0]    hint_r, hint_nxt;
  logic [LFB_W-1:0] lfb_r, lfb_nxt;
  op_t              op_r, op_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  status_t          res_st_r, res_st_nxt;
  logic             res_was_r, res_was_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  status_t          out_st_r, out_st_nxt;
  logic             out_was_r, out_was_nxt;

  logic [HW-1:0]     words_ext, hint_ext, addr_inc_ext;
  logic [AW-1:0]     addr_inc, q_word;
  logic [OFF_W-1:0]  op_off, zero_off;
  logic [WORD_W-1:0] op_mask, zero_mask;
  logic              op_was;
  logic              out_free;

  assign words_ext    = HW'(words_act);
  assign hint_ext     = HW'(hint_r);
  assign addr_inc_ext = HW'(addr_r) + HW'(1);
  assign addr_inc     = addr_r + 1'b1;
  assign q_word       = AW'(q_data.bit_index >> OFF_W);

  assign op_off    = op_r.bit_index[OFF_W-1:0];
  assign op_mask   = WORD_W'(1) << op_off;
  assign op_was    = ram_rdata[op_off];
  assign zero_off  = lowest_zero(ram_rdata);
  assign zero_mask = WORD_W'(1) << zero_off;

  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    addr_nxt      = addr_r;
    hint_nxt      = hint_r;
    lfb_nxt       = lfb_r;
    op_nxt        = op_r;
    res_idx_nxt   = res_idx_r;
    res_st_nxt    = res_st_r;
    res_was_nxt   = res_was_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    out_was_nxt   = out_was_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = addr_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_END_ADDR) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          op_nxt      = q_data;
          res_idx_nxt = q_data.bit_index;
          res_st_nxt  = ST_DONE;
          res_was_nxt = 1'b0;
          state_nxt   = S_RESP;
          case (q_data.cmd)
            CMD_ALLOC: begin
              res_idx_nxt = '0;
              if (hint_ext < words_ext) begin
                addr_nxt  = hint_r;
                state_nxt = S_READ;
              end else begin
                res_st_nxt = ST_FULL;
              end
            end
            CMD_FREE, CMD_SET: begin
              if (q_data.in_range) begin
                addr_nxt  = q_word;
                state_nxt = S_READ;
              end else begin
                res_st_nxt = ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = addr_r;
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        case (op_r.cmd)
          CMD_ALLOC: begin
            if (ram_rdata != FULL_WORD) begin
              ram_we      = 1'b1;
              ram_wdata   = ram_rdata | zero_mask;
              hint_nxt    = addr_r;
              res_idx_nxt = IDX_W'({addr_r, zero_off});
              state_nxt   = S_RESP;
            end else if (addr_inc_ext < words_ext) begin
              // next word read issued here, data checked next cycle
              ram_re    = 1'b1;
              ram_raddr = addr_inc;
              addr_nxt  = addr_inc;
            end else begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end
          end
          CMD_FREE: begin
            res_was_nxt = op_was;
            if (op_was) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~op_mask;
              if (LB_W'(op_r.bit_index) < LB_W'(lfb_r)) begin
                lfb_nxt  = LFB_W'(op_r.bit_index);
                hint_nxt = addr_r;
              end
            end
            state_nxt = S_RESP;
          end
          CMD_SET: begin
            res_was_nxt = op_was;
            ram_we      = 1'b1;
            ram_wdata   = ram_rdata | op_mask;
            state_nxt   = S_RESP;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_st_nxt    = res_st_r;
          out_was_nxt   = res_was_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    op_r      <= op_nxt;
    res_idx_r <= res_idx_nxt;
    res_st_r  <= res_st_nxt;
    res_was_r <= res_was_nxt;
    out_idx_r <= out_idx_nxt;
    out_st_r  <= out_st_nxt;
    out_was_r <= out_was_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      hint_r      <= '0;
      lfb_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hint_r      <= hint_nxt;
      lfb_r       <= lfb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign back_stat.clearing = (state_r == S_CLEAR);

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_status       = out_st_r;
  assign out_was_set      = out_was_r;

endmodule

`default_nettype wire

/* rtl/bitmap_id_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_id_allocator: first-free-bit identifier allocator
// bitmap of 32-bit words with a search hint; allocate, free and set commands
// ----------------------------------------------------------------------------
// The map lives in a simple dual-port memory of MAP_BITS/32 words (one
// write and one read per cycle). After reset the block clears every map
// word (128 by default) with in_ready low; config writes are taken during
// that time. An in-range free or set word passes from dequeue to result
// through pick up, memory read, check and update, and result load. An
// allocate adds a read and check for each all-ones word skipped above the
// search hint, since the scan reads one map word per cycle; an allocate with
// the hint already at or beyond words_in_use goes from pick up straight to
// result load and reports full; an out-of-range free or set and an unused
// code take that path too. A two-word command queue sits between the input
// and the engine, and the result sits in an output register, so new words
// keep arriving while a result waits to be taken. Allocation searches upward
// from the hint only: free bits below it are not found until a free moves
// the hint down. words_in_use is clamped to MAP_BITS/32; zero makes every
// free/set index out of range and every allocate full.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_id_allocator #(
  parameter int MAP_BITS = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // command words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic [bia_pkg::IDX_W-1:0]  in_bit_index,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bia_pkg::IDX_W-1:0]  out_result_index,
  output logic [1:0]                 out_status,
  output logic                       out_was_set,
  // words_in_use register
  input  logic                       cfg_wr_en,
  input  logic [bia_pkg::CFG_W-1:0]  cfg_words_in_use
);

  import bia_pkg::*;

  localparam int MAX_WORDS = MAP_BITS / 32;
  localparam int AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WCNT_W    = $clog2(MAX_WORDS + 1);

  // front to queue
  logic        q_push;
  op_t         q_push_data;
  logic        q_full;
  // queue to back
  logic        q_pop;
  op_t         q_pop_data;
  logic        q_empty;
  // shared status
  back_stat_t        back_stat;
  logic [WCNT_W-1:0] words_act;
  // map memory
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // accept and classify, hold the words_in_use register
  bia_front #(
    .MAP_BITS (MAP_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_bit_index     (in_bit_index),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_words_in_use (cfg_words_in_use),
    .q_full           (q_full),
    .back_stat        (back_stat),
    .q_push           (q_push),
    .q_data           (q_push_data),
    .words_act        (words_act)
  );

  // decouples input from the engine
  bia_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  // clear pass, hint scan, bit updates, result register
  bia_back #(
    .MAP_BITS (MAP_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_data           (q_pop_data),
    .words_act        (words_act),
    .back_stat        (back_stat),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_index (out_result_index),
    .out_status       (out_status),
    .out_was_set      (out_was_set)
  );

  // bitmap words
  bia_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

/* rtl/bia_checker.sv */
// ----------------------------------------------------------------------------
// bia_checker: port-level checks for the bitmap id allocator
// watches the top-level ports only; attached by bind
// ----------------------------------------------------------------------------
`default_nettype none

module bia_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bia_pkg::IDX_W-1:0] out_result_index,
  input logic [1:0]                out_status,
  input logic                      out_was_set
);

  import bia_pkg::*;

  // a full allocate reports index zero and no prior bit
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_result_index == '0) && !out_was_set)
    else $error("full result with nonzero index or was_set");

  // an out-of-range index never reports a prior bit
  a_range_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_RANGE) |-> !out_was_set)
    else $error("out-of-range result with was_set");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_index)
      && $stable(out_status) && $stable(out_was_set))
    else $error("result word changed while stalled");

  // the map clear after reset keeps the input closed
  a_reset_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (.*);

`default_nettype wire
